[src/mkd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, constants and the character lookup for the morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // field widths
  localparam int DOT_MS_W    = 16;
  localparam int DUR_W       = 32;
  localparam int CLASS_W     = 3;
  localparam int CHAR_W      = 7;
  localparam int SYM_W       = 8;
  localparam int CODE_LEN_W  = 3;
  localparam int CODE_BITS_W = 6;
  localparam int MAX_CODE_LEN = 6;

  // thresholds in microseconds: 1000 * (k * d + 1), k up to 4, d up to 65535
  localparam int THR_W     = 28;
  localparam int US_PER_MS = 1000;

  localparam logic [DOT_MS_W-1:0] DOT_MS_RESET = 16'd150;
  localparam logic [CHAR_W-1:0]   UNKNOWN_CHAR = 7'h23;
  localparam logic [CHAR_W-1:0]   NO_CHAR      = 7'h00;

  typedef enum logic [CLASS_W-1:0] {
    CLS_INTRA  = 3'd0,
    CLS_LETTER = 3'd1,
    CLS_WORD   = 3'd2,
    CLS_DOT    = 3'd3,
    CLS_DASH   = 3'd4
  } event_class_t;

  // duration compares against the dot multiples
  typedef struct packed {
    logic gt_2d;
    logic gt_4d;
  } dur_cmp_t;

  // pattern to ascii, len 0 matches nothing
  function automatic logic [CHAR_W-1:0] mkd_lookup(
    input logic [CODE_LEN_W-1:0]  len,
    input logic [CODE_BITS_W-1:0] bits
  );
    logic [CODE_LEN_W+CODE_BITS_W-1:0] key;
    logic [CHAR_W-1:0]                 ch;
    key = {len, bits};
    case (key)
      {3'd2, 6'd1}:  ch = 7'h41; // A
      {3'd4, 6'd8}:  ch = 7'h42; // B
      {3'd4, 6'd10}: ch = 7'h43; // C
      {3'd3, 6'd4}:  ch = 7'h44; // D
      {3'd1, 6'd0}:  ch = 7'h45; // E
      {3'd4, 6'd2}:  ch = 7'h46; // F
      {3'd3, 6'd6}:  ch = 7'h47; // G
      {3'd4, 6'd0}:  ch = 7'h48; // H
      {3'd2, 6'd0}:  ch = 7'h49; // I
      {3'd4, 6'd7}:  ch = 7'h4A; // J
      {3'd3, 6'd5}:  ch = 7'h4B; // K
      {3'd4, 6'd4}:  ch = 7'h4C; // L
      {3'd2, 6'd3}:  ch = 7'h4D; // M
      {3'd2, 6'd2}:  ch = 7'h4E; // N
      {3'd3, 6'd7}:  ch = 7'h4F; // O
      {3'd4, 6'd6}:  ch = 7'h50; // P
      {3'd4, 6'd13}: ch = 7'h51; // Q
      {3'd3, 6'd2}:  ch = 7'h52; // R
      {3'd3, 6'd0}:  ch = 7'h53; // S
      {3'd1, 6'd1}:  ch = 7'h54; // T
      {3'd3, 6'd1}:  ch = 7'h55; // U
      {3'd4, 6'd1}:  ch = 7'h56; // V
      {3'd3, 6'd3}:  ch = 7'h57; // W
      {3'd4, 6'd9}:  ch = 7'h58; // X
      {3'd4, 6'd11}: ch = 7'h59; // Y
      {3'd4, 6'd12}: ch = 7'h5A; // Z
      {3'd5, 6'd15}: ch = 7'h31; // 1
      {3'd5, 6'd7}:  ch = 7'h32; // 2
      {3'd5, 6'd3}:  ch = 7'h33; // 3
      {3'd5, 6'd1}:  ch = 7'h34; // 4
      {3'd5, 6'd0}:  ch = 7'h35; // 5
      {3'd5, 6'd16}: ch = 7'h36; // 6
      {3'd5, 6'd24}: ch = 7'h37; // 7
      {3'd5, 6'd28}: ch = 7'h38; // 8
      {3'd5, 6'd30}: ch = 7'h39; // 9
      {3'd5, 6'd31}: ch = 7'h30; // 0
      {3'd6, 6'd21}: ch = 7'h2E; // period
      {3'd6, 6'd51}: ch = 7'h2C; // comma
      {3'd6, 6'd56}: ch = 7'h3A; // colon
      {3'd6, 6'd12}: ch = 7'h3F; // question mark
      {3'd5, 6'd17}: ch = 7'h3D; // equals
      {3'd6, 6'd33}: ch = 7'h2D; // hyphen
      {3'd5, 6'd22}: ch = 7'h28; // open paren
      {3'd6, 6'd45}: ch = 7'h29; // close paren
      {3'd6, 6'd18}: ch = 7'h22; // double quote
      {3'd6, 6'd30}: ch = 7'h27; // apostrophe
      {3'd5, 6'd18}: ch = 7'h2F; // slash
      {3'd6, 6'd13}: ch = 7'h5F; // underscore
      {3'd6, 6'd26}: ch = 7'h40; // at sign
      {3'd6, 6'd43}: ch = 7'h21; // exclamation
      default:       ch = UNKNOWN_CHAR;
    endcase
    return ch;
  endfunction

endpackage

[src/mkd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd interfaces
// Valid/ready channels for key events, decoded results and the dot length.
// ----------------------------------------------------------------------------

// key event channel
interface mkd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] duration_us;

  modport source (output valid, output mode, output duration_us, input ready);
  modport sink   (input valid, input mode, input duration_us, output ready);
endinterface

// decoded result channel
interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_class;
  logic       letter_valid;
  logic [6:0] letter;
  logic       space_valid;

  modport source (output valid, output event_class, output letter_valid,
                  output letter, output space_valid, input ready);
  modport sink   (input valid, input event_class, input letter_valid,
                  input letter, input space_valid, output ready);
endinterface

// dot length write channel
interface mkd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/mkd_thresh.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd_thresh
// Holds the dot length as microsecond thresholds and compares durations.
// ----------------------------------------------------------------------------
module mkd_thresh (
  input  logic                     clk,
  input  logic                     rst_n,
  mkd_cfg_if.sink                  cfg_ch,
  input  logic [mkd_pkg::DUR_W-1:0] duration_us,
  output mkd_pkg::dur_cmp_t        cmp
);
  import mkd_pkg::*;

  // millis > k*d  <=>  us >= 1000*(k*d + 1)
  localparam logic [THR_W-1:0] MUL_2D = THR_W'(2 * US_PER_MS);
  localparam logic [THR_W-1:0] MUL_4D = THR_W'(4 * US_PER_MS);
  localparam logic [THR_W-1:0] ONE_MS = THR_W'(US_PER_MS);
  localparam logic [THR_W-1:0] THR2_RESET = THR_W'(DOT_MS_RESET) * MUL_2D + ONE_MS;
  localparam logic [THR_W-1:0] THR4_RESET = THR_W'(DOT_MS_RESET) * MUL_4D + ONE_MS;

  logic [THR_W-1:0] thr2_r, thr2_nxt;
  logic [THR_W-1:0] thr4_r, thr4_nxt;
  logic             cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid & cfg_ch.ready;

  // thresholds recomputed on each write
  always_comb begin
    thr2_nxt = THR_W'(cfg_ch.data) * MUL_2D + ONE_MS;
    thr4_nxt = THR_W'(cfg_ch.data) * MUL_4D + ONE_MS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr2_r <= THR2_RESET;
      thr4_r <= THR4_RESET;
    end else if (cfg_we) begin
      thr2_r <= thr2_nxt;
      thr4_r <= thr4_nxt;
    end
  end

  // duration compares
  assign cmp.gt_2d = duration_us >= DUR_W'(thr2_r);
  assign cmp.gt_4d = duration_us >= DUR_W'(thr4_r);

`ifndef NO_ASSERTIONS
  // word gap threshold never below letter gap threshold
  a_thr_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmp.gt_4d |-> cmp.gt_2d)
    else $error("mkd_thresh: 4d compare set without 2d compare");
`endif

endmodule

[src/morse_key_timing_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_unit
// Morse decoder for timed key events: classifies marks and silences against
// the dot length, collects the symbol pattern and emits decoded characters.
// ----------------------------------------------------------------------------
// One key event is taken per clock and its result appears in the output
// register on the next cycle; the pattern state and the result are written in
// the same single pass, so the sustained rate is one item per cycle for as
// long as the result side takes items. The output register decouples the two
// sides: a new item is accepted whenever the register is empty or is being
// drained in that cycle. A dot length write takes effect for the next item.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_unit #(
  parameter int MAX_SYMBOLS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  mkd_in_if.sink     in_ch,
  mkd_out_if.source  out_ch,
  mkd_cfg_if.sink    cfg_ch
);
  import mkd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  logic [SYM_W-1:0]  bits_r, bits_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r;
  event_class_t      cls_r, cls_nxt;
  logic              lv_r, lv_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              sv_r, sv_nxt;

  logic              in_acc;
  dur_cmp_t          cmp;
  logic              code_fits;
  logic [CODE_LEN_W-1:0] code_len;
  logic [CHAR_W-1:0] looked_up;

  // threshold compare unit
  mkd_thresh u_thresh (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .duration_us (in_ch.duration_us),
    .cmp         (cmp)
  );

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // character lookup on the stored pattern
  always_comb begin
    code_fits = (count_r <= CNT_W'(MAX_CODE_LEN)) && (bits_r[SYM_W-1:CODE_BITS_W] == '0);
    code_len  = code_fits ? count_r[CODE_LEN_W-1:0] : '0;
    looked_up = ovf_r ? UNKNOWN_CHAR : mkd_lookup(code_len, bits_r[CODE_BITS_W-1:0]);
  end

  // event decode and pattern update
  always_comb begin
    bits_nxt  = bits_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    cls_nxt   = CLS_INTRA;
    lv_nxt    = 1'b0;
    ch_nxt    = NO_CHAR;
    sv_nxt    = 1'b0;
    if (!in_ch.mode) begin
      if (cmp.gt_4d) begin
        cls_nxt = CLS_WORD;
        sv_nxt  = 1'b1;
        if ((count_r != '0) || ovf_r) begin
          lv_nxt = 1'b1;
          ch_nxt = looked_up;
        end
        bits_nxt  = '0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (cmp.gt_2d) begin
        cls_nxt   = CLS_LETTER;
        lv_nxt    = 1'b1;
        ch_nxt    = looked_up;
        bits_nxt  = '0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end else begin
      cls_nxt = cmp.gt_2d ? CLS_DASH : CLS_DOT;
      if (count_r >= CNT_W'(MAX_SYMBOLS)) begin
        ovf_nxt = 1'b1;
      end else begin
        bits_nxt  = {bits_r[SYM_W-2:0], cmp.gt_2d};
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // control and pattern state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        bits_r  <= bits_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cls_r <= cls_nxt;
      lv_r  <= lv_nxt;
      ch_r  <= ch_nxt;
      sv_r  <= sv_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_class  = cls_r;
  assign out_ch.letter_valid = lv_r;
  assign out_ch.letter       = ch_r;
  assign out_ch.space_valid  = sv_r;

`ifndef NO_ASSERTIONS
  // pattern count stays within capacity
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SYMBOLS))
    else $error("mkd: symbol count beyond capacity");

  // overflow only once the pattern is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_W'(MAX_SYMBOLS)))
    else $error("mkd: overflow flag with pattern not full");

  // a delivered gap result leaves an empty pattern
  a_gap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.mode && cmp.gt_2d) |=> ((count_r == '0) && !ovf_r))
    else $error("mkd: pattern not cleared after letter or word gap");

  // letters and spaces only come with gap classes
  a_letter_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (lv_r || sv_r)) |-> ((cls_r == CLS_LETTER) || (cls_r == CLS_WORD)))
    else $error("mkd: letter or space on a non-gap result");
`endif

endmodule

[verif/tb_morse_key_timing_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_key_timing_decoder_unit
// Self-checking bench for the morse key decoder. A short table of key events
// covers the thresholds, the empty and pending pattern cases and overflow.
// Random letter sequences follow under several dot lengths, including the
// extremes. Each result is checked field by field against a software decoder.
// Random idle cycles occur on both sides, and one long result stall fills the
// block.
// ----------------------------------------------------------------------------
module tb_morse_key_timing_decoder_unit;
  import mkd_pkg::*;

  localparam int MAX_SYMBOLS  = 8;
  localparam int IDLE_PCT     = 29;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam longint unsigned MAX_MS = 64'd4294967;

  localparam logic MODE_SILENCE = 1'b0;
  localparam logic MODE_MARK    = 1'b1;

  typedef enum int {SPAN_SHORT, SPAN_MID, SPAN_LONG} span_t;

  typedef struct packed {
    event_class_t      cls;
    logic              lv;
    logic [CHAR_W-1:0] ch;
    logic              sv;
  } key_result_t;

  typedef struct packed {
    logic             mode;
    logic [DUR_W-1:0] dur;
    logic             fixed;
    key_result_t      res;
  } key_row_t;

  logic clk;
  logic rst_n;

  mkd_in_if  in_ch();
  mkd_out_if out_ch();
  mkd_cfg_if cfg_ch();

  morse_key_timing_decoder_unit #(.MAX_SYMBOLS(MAX_SYMBOLS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // decoder state mirrored by the bench
  logic [SYM_W-1:0]    sym_bits;
  logic [3:0]          sym_count;
  logic                sym_overflow;
  logic [DOT_MS_W-1:0] dot_len_ms;

  logic [CHAR_W-1:0] morse_chars [int];
  int                code_keys [$];
  key_result_t       expected_results [$];
  key_row_t          dir_rows [$];

  int events_sent;
  int results_checked;
  int mismatches;
  int quiet_cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character table keyed by length * 256 + pattern, dash = 1
  task automatic load_code_table();
    string codes;
    int    i;
    int    len;
    int    bits;
    byte   ch;
    codes = {"A.- B-... C-.-. D-.. E. F..-. G--. H.... I.. J.--- K-.- L.-.. M-- ",
             "N-. O--- P.--. Q--.- R.-. S... T- U..- V...- W.-- X-..- Y-.-- Z--.. ",
             "1.---- 2..--- 3...-- 4....- 5..... 6-.... 7--... 8---.. 9----. ",
             "0----- ..-.-.- ,--..-- :---... ?..--.. =-...- --....- (-.--. ",
             ")-.--.- \".-..-. '.----. /-..-. _..--.- @.--.-. !-.-.--"};
    i = 0;
    while (i < codes.len()) begin
      ch   = codes[i];
      i    = i + 1;
      len  = 0;
      bits = 0;
      while (i < codes.len() && codes[i] != " ") begin
        bits = bits * 2 + ((codes[i] == "-") ? 1 : 0);
        len  = len + 1;
        i    = i + 1;
      end
      morse_chars[len * 256 + bits] = ch[CHAR_W-1:0];
      code_keys.push_back(len * 256 + bits);
      i = i + 1;
    end
  endtask

  function automatic void clear_pattern();
    sym_bits     = '0;
    sym_count    = '0;
    sym_overflow = 1'b0;
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char();
    int key;
    key = int'(sym_count) * 256 + int'(sym_bits);
    if (sym_overflow || !morse_chars.exists(key)) return UNKNOWN_CHAR;
    return morse_chars[key];
  endfunction

  // classify one key event and update the symbol pattern
  function automatic key_result_t decode_key_event(input logic mode,
                                                   input logic [DUR_W-1:0] dur);
    longint unsigned ms;
    longint unsigned d;
    key_result_t     r;
    logic            dash;
    ms    = {32'd0, dur} / 64'd1000;
    d     = {48'd0, dot_len_ms};
    r.cls = CLS_INTRA;
    r.lv  = 1'b0;
    r.ch  = NO_CHAR;
    r.sv  = 1'b0;
    if (mode == MODE_SILENCE) begin
      if (ms > 4 * d) begin
        r.cls = CLS_WORD;
        r.sv  = 1'b1;
        if (sym_count != 0 || sym_overflow) begin
          r.lv = 1'b1;
          r.ch = pattern_char();
        end
        clear_pattern();
      end else if (ms > 2 * d) begin
        r.cls = CLS_LETTER;
        r.lv  = 1'b1;
        r.ch  = pattern_char();
        clear_pattern();
      end
    end else begin
      dash  = (ms > 2 * d);
      r.cls = dash ? CLS_DASH : CLS_DOT;
      if (sym_count >= MAX_SYMBOLS) begin
        sym_overflow = 1'b1;
      end else begin
        sym_bits  = {sym_bits[SYM_W-2:0], dash};
        sym_count = sym_count + 1'b1;
      end
    end
    return r;
  endfunction

  // duration whose millisecond count falls in the wanted span of the dot length
  function automatic logic [DUR_W-1:0] pick_duration(input span_t span);
    longint unsigned d;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned ms;
    longint unsigned us;
    d = {48'd0, dot_len_ms};
    case (span)
      SPAN_SHORT: begin
        lo = 0;
        hi = 2 * d;
      end
      SPAN_MID: begin
        lo = 2 * d + 1;
        hi = 4 * d;
      end
      default: begin
        lo = 4 * d + 1;
        hi = ($urandom_range(0, 3) == 0) ? MAX_MS : 8 * d + 1;
      end
    endcase
    if (hi < lo) hi = lo;
    case ($urandom_range(0, 7))
      0:       ms = lo;
      1:       ms = hi;
      default: ms = lo + $urandom_range(0, 32'(hi - lo));
    endcase
    us = ms * 1000 + $urandom_range(0, 999);
    if (us > 64'hFFFF_FFFF) us = 64'hFFFF_FFFF;
    return us[DUR_W-1:0];
  endfunction

  task automatic add_row(input logic mode, input logic [DUR_W-1:0] dur, input logic fixed,
                         input event_class_t cls, input logic lv,
                         input logic [CHAR_W-1:0] ch, input logic sv);
    key_row_t row;
    row.mode    = mode;
    row.dur     = dur;
    row.fixed   = fixed;
    row.res.cls = cls;
    row.res.lv  = lv;
    row.res.ch  = ch;
    row.res.sv  = sv;
    dir_rows.push_back(row);
  endtask

  // offer one item; the predicted or typed result is queued on acceptance
  task automatic offer_event(input logic mode, input logic [DUR_W-1:0] dur,
                             input logic fixed, input key_result_t typed);
    key_result_t pred;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.duration_us <= dur;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = decode_key_event(mode, dur);
    expected_results.push_back(fixed ? typed : pred);
    events_sent = events_sent + 1;
  endtask

  task automatic send_key_event(input logic mode, input logic [DUR_W-1:0] dur);
    offer_event(mode, dur, 1'b0, '0);
  endtask

  // marks and gaps for one character, sometimes left open or garbled
  task automatic send_letter();
    int   key;
    int   len;
    int   bits;
    logic dash;
    if ($urandom_range(0, 9) < 7) begin
      key  = code_keys[$urandom_range(0, code_keys.size() - 1)];
      len  = key / 256;
      bits = key % 256;
    end else begin
      len  = $urandom_range(0, MAX_SYMBOLS + 2);
      bits = $urandom_range(0, 1023);
    end
    for (int k = len - 1; k >= 0; k--) begin
      dash = bits[k];
      send_key_event(MODE_MARK,
                     pick_duration(dash ? ($urandom_range(0, 3) == 0 ? SPAN_LONG : SPAN_MID)
                                        : SPAN_SHORT));
      if (k > 0) send_key_event(MODE_SILENCE, pick_duration(SPAN_SHORT));
    end
    if ($urandom_range(0, 9) != 0)
      send_key_event(MODE_SILENCE, pick_duration($urandom_range(0, 1) ? SPAN_MID : SPAN_LONG));
  endtask

  task automatic run_random(input int count);
    int target;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_key_event(1'($urandom_range(0, 1)), $urandom());
      else send_letter();
    end
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_dot_length(input logic [DOT_MS_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    dot_len_ms = value;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("result %0d: %s is %0d, expected %0d", results_checked, field, got, want);
    mismatches = mismatches + 1;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, event_class", int'(out_ch.event_class), -1);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.event_class !== want.cls)
          report_mismatch("event_class", int'(out_ch.event_class), int'(want.cls));
        if (out_ch.letter_valid !== want.lv)
          report_mismatch("letter_valid", int'(out_ch.letter_valid), int'(want.lv));
        if (out_ch.letter !== want.ch)
          report_mismatch("letter", int'(out_ch.letter), int'(want.ch));
        if (out_ch.space_valid !== want.sv)
          report_mismatch("space_valid", int'(out_ch.space_valid), int'(want.sv));
      end
      results_checked = results_checked + 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && events_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_SILENCE;
    in_ch.duration_us <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    events_sent     = 0;
    results_checked = 0;
    mismatches      = 0;
    no_gaps         = 1'b0;
    dot_len_ms      = DOT_MS_RESET;
    clear_pattern();
    load_code_table();

    // directed events at the reset dot length: 2d = 300 ms, 4d = 600 ms
    add_row(MODE_SILENCE, 32'd0,          1'b1, CLS_INTRA,  1'b0, NO_CHAR,      1'b0);
    add_row(MODE_SILENCE, 32'hFFFF_FFFF,  1'b1, CLS_WORD,   1'b0, NO_CHAR,      1'b1);
    add_row(MODE_SILENCE, 32'd301_000,    1'b1, CLS_LETTER, 1'b1, UNKNOWN_CHAR, 1'b0);
    add_row(MODE_MARK,    32'd0,          1'b1, CLS_DOT,    1'b0, NO_CHAR,      1'b0);
    add_row(MODE_MARK,    32'd300_999,    1'b1, CLS_DOT,    1'b0, NO_CHAR,      1'b0);
    add_row(MODE_SILENCE, 32'd300_999,    1'b1, CLS_INTRA,  1'b0, NO_CHAR,      1'b0);
    add_row(MODE_MARK,    32'd301_000,    1'b1, CLS_DASH,   1'b0, NO_CHAR,      1'b0);
    add_row(MODE_SILENCE, 32'd301_000,    1'b1, CLS_LETTER, 1'b1, 7'h55,        1'b0); // U
    add_row(MODE_MARK,    32'hFFFF_FFFF,  1'b0, CLS_DASH,   1'b0, NO_CHAR,      1'b0);
    add_row(MODE_MARK,    32'd999,        1'b0, CLS_DOT,    1'b0, NO_CHAR,      1'b0);
    add_row(MODE_SILENCE, 32'd600_999,    1'b1, CLS_LETTER, 1'b1, 7'h4E,        1'b0); // N
    // pending letter closed by a word gap
    for (int i = 0; i < 3; i++)
      add_row(MODE_MARK, 32'd150_000, 1'b0, CLS_DOT, 1'b0, NO_CHAR, 1'b0);
    add_row(MODE_SILENCE, 32'd601_000,    1'b1, CLS_WORD,   1'b1, 7'h53,        1'b1); // S
    // one symbol past a full pattern
    for (int i = 0; i <= MAX_SYMBOLS; i++)
      add_row(MODE_MARK, 32'd450_000, 1'b0, CLS_DASH, 1'b0, NO_CHAR, 1'b0);
    add_row(MODE_SILENCE, 32'd600_999,    1'b1, CLS_LETTER, 1'b1, UNKNOWN_CHAR, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      offer_event(dir_rows[i].mode, dir_rows[i].dur, dir_rows[i].fixed, dir_rows[i].res);
    run_random(150);

    // dot length sweep, smallest and largest included
    write_dot_length(16'd1);
    run_random(150);
    no_gaps = 1'b1;
    write_dot_length(16'hFFFF);
    run_random(150);
    no_gaps = 1'b0;
    write_dot_length(16'd0);
    run_random(60);
    write_dot_length(16'($urandom_range(2, 400)));
    run_random(150);
    write_dot_length(16'($urandom_range(401, 65534)));
    run_random(150);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
